// ===== sv/mcdt_pkg.sv =====
// Package for the multi-channel deadline timer.
// Holds the command codes, field widths, sequencer states and timing constants.
// No dependencies.
package mcdt_pkg;

    // Default size of the timer bank
    localparam int NUM_TIMERS_DEF = 16;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 32;
    localparam int TIME_W   = 64;

    // Milliseconds to microseconds
    localparam int unsigned US_PER_MS = 1000;
    localparam int          MS_W      = 10;   // bits needed for US_PER_MS
    localparam int          PROD_W    = PERIOD_W + MS_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_PRD,
        S_PCMP,
        S_PEND
    } state_t;

endpackage

// ===== sv/multi_channel_deadline_timer.sv =====
// Multi-channel deadline timer: top level with sequencer, timer stores and result register.
// Depends on mcdt_pkg.
//
// A bank of NUM_TIMERS timers driven by one word at a time. A start word (the block is
// busy: multiply, then add and write) stores the period and periodic flag and sets the
// deadline to now + max(period,1)*1000; a stop word disarms in the accept cycle; cmd 3 and
// out-of-range timer ids are dropped. A poll walks the bank with one shared comparator and
// one shared multiply/add unit: an idle timer is skipped and an armed timer is read, then
// compared; an expired timer is disarmed, a periodic one re-armed with a new deadline.
// Expired timers are reported in ascending index order, the final one with m_last_fired set;
// each result leaves through an output register, and the walk pauses while that register
// is still full. The block takes no new word while a start or poll is under way.
module multi_channel_deadline_timer #(
    parameter int NUM_TIMERS = mcdt_pkg::NUM_TIMERS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mcdt_pkg::CMD_W-1:0]    s_cmd,
    input  logic [mcdt_pkg::ID_W-1:0]     s_timer_id,
    input  logic [mcdt_pkg::PERIOD_W-1:0] s_period_ms,
    input  logic                          s_repeat_req,
    input  logic [mcdt_pkg::TIME_W-1:0]   s_now_us,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcdt_pkg::ID_W-1:0]     m_fired_id,
    output logic                          m_last_fired
);
    import mcdt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    // Control state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [NUM_TIMERS-1:0]   armed_reg, armed_next;
    logic                    hold_vld_reg, hold_vld_next;
    logic [IDX_W-1:0]        hold_id_reg, hold_id_next;
    logic                    m_valid_reg;
    logic [ID_W-1:0]         m_fired_id_reg;
    logic                    m_last_reg;

    // Latched word
    logic [CMD_W-1:0]        cmd_reg;
    logic [ID_W-1:0]         id_reg;
    logic [PERIOD_W-1:0]     per_reg;
    logic                    rep_reg;
    logic [TIME_W-1:0]       now_reg;

    // Stores and their registered read data
    logic [TIME_W-1:0]       deadline_mem [NUM_TIMERS];
    logic [PERIOD_W-1:0]     period_mem   [NUM_TIMERS];
    logic                    repeat_mem   [NUM_TIMERS];
    logic [TIME_W-1:0]       dl_rd_reg;
    logic [PERIOD_W-1:0]     per_rd_reg;
    logic                    rep_rd_reg;

    // Shared multiply result
    logic [PROD_W-1:0]       prod_reg, prod_next;

    // Sequencer strobes
    logic                    latch_en;
    logic                    rd_en;
    logic                    mem_we;
    logic                    prod_en;
    logic                    push_en;
    logic                    push_last;
    logic                    out_free;
    logic                    in_range;
    logic                    expired;
    logic [IDX_W-1:0]        idx_lo;
    logic [IDX_W-1:0]        wr_idx;
    logic [PERIOD_W-1:0]     mul_op;
    logic [PERIOD_W-1:0]     mul_eff;
    logic [TIME_W-1:0]       dl_wdata;

    assign idx_lo   = idx_reg[IDX_W-1:0];
    assign in_range = (32'(s_timer_id) < 32'(NUM_TIMERS));
    assign out_free = !m_valid_reg || m_ready;
    assign expired  = !(now_reg < dl_rd_reg);
    assign wr_idx   = (cmd_reg == CMD_POLL) ? idx_lo : IDX_W'(id_reg);

    // Shared unit: max(period,1) * 1000, then now + product
    assign mul_op    = (state_reg == S_MUL) ? per_reg : per_rd_reg;
    assign mul_eff   = (mul_op == '0) ? PERIOD_W'(1) : mul_op;
    assign prod_next = PROD_W'(mul_eff) * PROD_W'(US_PER_MS);
    assign dl_wdata  = now_reg + TIME_W'(prod_reg);

    // Next state and strobes
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        armed_next    = armed_reg;
        hold_vld_next = hold_vld_reg;
        hold_id_next  = hold_id_reg;
        latch_en      = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        prod_en       = 1'b0;
        push_en       = 1'b0;
        push_last     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    latch_en = 1'b1;
                    case (s_cmd)
                        CMD_POLL: begin
                            idx_next   = '0;
                            state_next = S_PRD;
                        end
                        CMD_START: begin
                            if (in_range) begin
                                state_next = S_MUL;
                            end
                        end
                        CMD_STOP: begin
                            if (in_range) begin
                                armed_next[IDX_W'(s_timer_id)] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                prod_en    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                mem_we             = 1'b1;
                armed_next[wr_idx] = 1'b1;
                if (cmd_reg == CMD_POLL) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_PRD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PRD: begin
                if (idx_reg == CNT_W'(NUM_TIMERS)) begin
                    state_next = S_PEND;
                end else if (!armed_reg[idx_lo]) begin
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_PCMP;
                end
            end
            S_PCMP: begin
                if (!expired) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_PRD;
                end else if (!(hold_vld_reg && !out_free)) begin
                    // previous expiry is not the last one: send it on
                    push_en            = hold_vld_reg;
                    hold_vld_next      = 1'b1;
                    hold_id_next       = idx_lo;
                    armed_next[idx_lo] = 1'b0;
                    if (rep_rd_reg) begin
                        prod_en    = 1'b1;
                        state_next = S_ADD;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_PRD;
                    end
                end
            end
            S_PEND: begin
                if (!hold_vld_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    push_en       = 1'b1;
                    push_last     = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            armed_reg    <= '0;
            hold_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            armed_reg    <= armed_next;
            hold_vld_reg <= hold_vld_next;
            if (push_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hold_id_reg <= hold_id_next;
        if (latch_en) begin
            cmd_reg <= s_cmd;
            id_reg  <= s_timer_id;
            per_reg <= s_period_ms;
            rep_reg <= s_repeat_req;
            now_reg <= s_now_us;
        end
        if (prod_en) begin
            prod_reg <= prod_next;
        end
        if (push_en) begin
            m_fired_id_reg <= ID_W'(hold_id_reg);
            m_last_reg     <= push_last;
        end
    end

    // Timer stores: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            deadline_mem[wr_idx] <= dl_wdata;
            if (cmd_reg != CMD_POLL) begin
                period_mem[wr_idx] <= per_reg;
                repeat_mem[wr_idx] <= rep_reg;
            end
        end
        if (rd_en) begin
            dl_rd_reg  <= deadline_mem[idx_lo];
            per_rd_reg <= period_mem[idx_lo];
            rep_rd_reg <= repeat_mem[idx_lo];
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_fired_id   = m_fired_id_reg;
    assign m_last_fired = m_last_reg;

    // Checks
    a_idle_no_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !hold_vld_reg)
        else $error("pending expiry left behind at end of poll");

    a_push_free : assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> out_free)
        else $error("result register overwritten");

    a_mid_result_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (state_reg != S_IDLE))
        else $error("non-final result while idle");

    a_fire_disarms : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PCMP && expired && !(hold_vld_reg && !out_free))
        |=> !armed_reg[$past(idx_lo)])
        else $error("expired timer not disarmed");

    a_start_write : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |=> (state_reg == S_ADD && mem_we))
        else $error("start did not write deadline");

endmodule
